// ===== hw/rtl/zero_suppression_bitmask_packer_macros.svh =====
// Assertion macros for the zero-suppression bitmask packer checker.
`ifndef ZERO_SUPPRESSION_BITMASK_PACKER_MACROS_SVH
`define ZERO_SUPPRESSION_BITMASK_PACKER_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ZSBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ZSBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/zsbp_pkg.sv =====
// Package: shared types and constants for the zero-suppression bitmask packer.
`default_nettype none

package zsbp_pkg;

    localparam int MASK_BITS = 64;
    localparam int POS_W     = $clog2(MASK_BITS);
    localparam int VALUE_W   = 64;
    localparam int THRESH_W  = 63;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 64;

    localparam logic [1:0] KIND_VALUE  = 2'd0;
    localparam logic [1:0] KIND_MASK   = 2'd1;
    localparam logic [1:0] KIND_TOTALS = 2'd2;

    // register select is paddr[3]: 8-byte register slots
    localparam logic REG_SINGLE = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    localparam logic              SINGLE_RESET = 1'b1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 63'd758115327;

    localparam logic [30:0] F32_INF = 31'h7F80_0000;
    localparam logic [62:0] F64_INF = 63'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic                single_precision;
        logic [THRESH_W-1:0] zero_threshold;
    } cfg_t;

    typedef struct packed {
        logic has_value;
        logic has_mask;
        logic has_totals;
    } job_ctrl_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [MASK_BITS-1:0] mask_word;
    } job_data_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zero_suppression_bitmask_packer.sv =====
// Top level of the zero-suppression bitmask packer.
//
// Input channel: sample_bits/final_sample with in_valid/in_stall; a transfer
// happens on a clock edge with in_valid high and in_stall low. Each sample
// adds one bit (1 = zero) to a 64-bit mask word, LSB first.
// Output channel: item_kind/payload/samples_seen/nonzero_seen/end_of_run with
// out_valid/out_stall. Per sample, in order: the value if nonzero, the mask
// word when full or on the final sample (unused bits 1), and a totals item on
// the final sample.
// Results leave through the output register. The input takes one sample per
// cycle while out_stall is low and each sample yields at most one result; a
// sample with two or three results holds the single output register for one
// transfer per result. Samples with no result never reach the output.
// A QUEUE_DEPTH-entry job queue sits between the classifier and the output
// sequencer; in_stall rises only when the queue is full, so an out_stall
// reaches the input after QUEUE_DEPTH + 1 pending jobs.
// Reset fills the mask with ones, clears the bit position, counters, queue and
// output valid, and loads single precision mode with the 1e-11 float threshold.
// Registers are written over the APB port; the user must write them only while
// no transfers are pending, as the block itself does not enforce this.
`default_nettype none

module zero_suppression_bitmask_packer #(
    parameter int COUNT_WIDTH = 40,
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [zsbp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [zsbp_pkg::DATA_W-1:0]  pwdata,
    output logic      [zsbp_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [zsbp_pkg::VALUE_W-1:0] sample_bits,
    input  wire logic                         final_sample,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [1:0]                   item_kind,
    output logic      [zsbp_pkg::VALUE_W-1:0] payload,
    output logic      [COUNT_WIDTH-1:0]       samples_seen,
    output logic      [COUNT_WIDTH-1:0]       nonzero_seen,
    output logic                              end_of_run
);
    import zsbp_pkg::*;

    localparam int JOB_W = $bits(job_ctrl_t) + $bits(job_data_t) + 2 * COUNT_WIDTH;

    cfg_t                   cfg;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;
    job_ctrl_t              push_ctrl;
    job_data_t              push_data;
    logic [COUNT_WIDTH-1:0] push_samples;
    logic [COUNT_WIDTH-1:0] push_nonzero;
    job_ctrl_t              head_ctrl;
    job_data_t              head_data;
    logic [COUNT_WIDTH-1:0] head_samples;
    logic [COUNT_WIDTH-1:0] head_nonzero;
    logic [JOB_W-1:0]       push_word;
    logic [JOB_W-1:0]       head_word;

    zsbp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    zsbp_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_bits  (sample_bits),
        .final_sample (final_sample),
        .queue_full   (queue_full),
        .push         (push),
        .job_ctrl     (push_ctrl),
        .job_data     (push_data),
        .job_samples  (push_samples),
        .job_nonzero  (push_nonzero)
    );

    assign push_word = {push_ctrl, push_data, push_samples, push_nonzero};
    assign {head_ctrl, head_data, head_samples, head_nonzero} = head_word;

    zsbp_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_word),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_word),
        .empty     (queue_empty)
    );

    zsbp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .head_ctrl    (head_ctrl),
        .head_data    (head_data),
        .head_samples (head_samples),
        .head_nonzero (head_nonzero),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .payload      (payload),
        .samples_seen (samples_seen),
        .nonzero_seen (nonzero_seen),
        .end_of_run   (end_of_run)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/zsbp_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none

module zsbp_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [zsbp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [zsbp_pkg::DATA_W-1:0] pwdata,
    output logic      [zsbp_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output zsbp_pkg::cfg_t                   cfg
);
    import zsbp_pkg::*;

    logic                wr_en;
    logic                reg_sel;
    logic                single_reg;
    logic [THRESH_W-1:0] thresh_reg;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_reg <= SINGLE_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SINGLE: single_reg <= pwdata[0];
                REG_THRESH: thresh_reg <= pwdata[THRESH_W-1:0];
                default:    single_reg <= single_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SINGLE: prdata = {{(DATA_W-1){1'b0}}, single_reg};
            REG_THRESH: prdata = {{(DATA_W-THRESH_W){1'b0}}, thresh_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.single_precision = single_reg;
    assign cfg.zero_threshold   = thresh_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/zsbp_front.sv =====
// Front end: accepts samples, classifies them and builds the mask and counts.
`default_nettype none

module zsbp_front #(
    parameter int COUNT_WIDTH = 40
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire zsbp_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [zsbp_pkg::VALUE_W-1:0] sample_bits,
    input  wire logic                         final_sample,
    input  wire logic                         queue_full,
    output logic                              push,
    output zsbp_pkg::job_ctrl_t               job_ctrl,
    output zsbp_pkg::job_data_t               job_data,
    output logic      [COUNT_WIDTH-1:0]       job_samples,
    output logic      [COUNT_WIDTH-1:0]       job_nonzero
);
    import zsbp_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [MASK_BITS-1:0]   mask_reg,    mask_next;
    logic [POS_W-1:0]       pos_reg,     pos_next;
    logic [COUNT_WIDTH-1:0] samples_reg, samples_next;
    logic [COUNT_WIDTH-1:0] nonzero_reg, nonzero_next;

    logic                   accept;
    logic [THRESH_W-1:0]    mag;
    logic                   is_nan;
    logic [VALUE_W-1:0]     value_sel;
    logic                   nonzero;
    logic [MASK_BITS-1:0]   mask_upd;
    logic                   word_done;
    logic [COUNT_WIDTH-1:0] samples_inc;
    logic [COUNT_WIDTH-1:0] nonzero_inc;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        if (cfg.single_precision)
        begin
            mag       = {32'd0, sample_bits[30:0]};
            is_nan    = sample_bits[30:0] > F32_INF;
            value_sel = {32'd0, sample_bits[31:0]};
        end
        else
        begin
            mag       = sample_bits[62:0];
            is_nan    = sample_bits[62:0] > F64_INF;
            value_sel = sample_bits;
        end
    end

    assign nonzero   = !is_nan && (mag > cfg.zero_threshold);
    assign mask_upd  = nonzero ? (mask_reg & ~(MASK_BITS'(1) << pos_reg)) : mask_reg;
    assign word_done = (pos_reg == POS_W'(MASK_BITS - 1)) || final_sample;

    assign samples_inc = (samples_reg == CNT_MAX) ? samples_reg : samples_reg + 1'b1;
    assign nonzero_inc = (nonzero && nonzero_reg != CNT_MAX) ? nonzero_reg + 1'b1
                                                              : nonzero_reg;

    assign job_data            = {value_sel, mask_upd};
    assign job_ctrl.has_value  = nonzero;
    assign job_ctrl.has_mask   = word_done;
    assign job_ctrl.has_totals = final_sample;
    assign job_samples         = samples_inc;
    assign job_nonzero         = nonzero_inc;
    assign push                = accept && (nonzero || word_done);

    always_comb
    begin
        mask_next    = mask_reg;
        pos_next     = pos_reg;
        samples_next = samples_reg;
        nonzero_next = nonzero_reg;
        if (accept)
        begin
            if (word_done)
            begin
                mask_next = '1;
                pos_next  = '0;
            end
            else
            begin
                mask_next = mask_upd;
                pos_next  = pos_reg + 1'b1;
            end
            if (final_sample)
            begin
                samples_next = '0;
                nonzero_next = '0;
            end
            else
            begin
                samples_next = samples_inc;
                nonzero_next = nonzero_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '1;
            pos_reg     <= '0;
            samples_reg <= '0;
            nonzero_reg <= '0;
        end
        else
        begin
            mask_reg    <= mask_next;
            pos_reg     <= pos_next;
            samples_reg <= samples_next;
            nonzero_reg <= nonzero_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/zsbp_fifo.sv =====
// Small register FIFO between the front and back ends.
`default_nettype none

module zsbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = storage_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            storage_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/zsbp_back.sv =====
// Back end: expands each queued job into value, mask and totals transfers.
`default_nettype none

module zsbp_back #(
    parameter int COUNT_WIDTH = 40
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           queue_empty,
    output logic                                pop,
    input  wire zsbp_pkg::job_ctrl_t            head_ctrl,
    input  wire zsbp_pkg::job_data_t            head_data,
    input  wire logic [COUNT_WIDTH-1:0]         head_samples,
    input  wire logic [COUNT_WIDTH-1:0]         head_nonzero,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [1:0]                     item_kind,
    output logic      [zsbp_pkg::VALUE_W-1:0]   payload,
    output logic      [COUNT_WIDTH-1:0]         samples_seen,
    output logic      [COUNT_WIDTH-1:0]         nonzero_seen,
    output logic                                end_of_run
);
    import zsbp_pkg::*;

    job_ctrl_t              pend_reg, pend_next, pend_left;
    job_data_t              data_reg;
    logic [COUNT_WIDTH-1:0] jsamp_reg;
    logic [COUNT_WIDTH-1:0] jnz_reg;

    logic                   ovalid_reg, ovalid_next;
    logic [1:0]             kind_reg,   kind_next;
    logic [VALUE_W-1:0]     payload_reg, payload_next;
    logic [COUNT_WIDTH-1:0] osamp_reg;
    logic [COUNT_WIDTH-1:0] onz_reg;
    logic                   can_load;
    logic                   emit;

    assign can_load = !ovalid_reg || !out_stall;
    assign emit     = can_load && (pend_reg != '0);

    always_comb
    begin
        pend_left    = pend_reg;
        kind_next    = kind_reg;
        payload_next = payload_reg;
        if (emit)
        begin
            priority if (pend_reg.has_value)
            begin
                kind_next           = KIND_VALUE;
                payload_next        = data_reg.value;
                pend_left.has_value = 1'b0;
            end
            else if (pend_reg.has_mask)
            begin
                kind_next          = KIND_MASK;
                payload_next       = data_reg.mask_word;
                pend_left.has_mask = 1'b0;
            end
            else
            begin
                kind_next            = KIND_TOTALS;
                payload_next         = '0;
                pend_left.has_totals = 1'b0;
            end
        end
    end

    assign pop         = (pend_left == '0) && !queue_empty;
    assign pend_next   = pop ? head_ctrl : pend_left;
    assign ovalid_next = can_load ? emit : ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg  <= head_data;
            jsamp_reg <= head_samples;
            jnz_reg   <= head_nonzero;
        end
        if (emit)
        begin
            kind_reg    <= kind_next;
            payload_reg <= payload_next;
            osamp_reg   <= jsamp_reg;
            onz_reg     <= jnz_reg;
        end
    end

    assign out_valid    = ovalid_reg;
    assign item_kind    = kind_reg;
    assign payload      = payload_reg;
    assign samples_seen = osamp_reg;
    assign nonzero_seen = onz_reg;
    assign end_of_run   = (kind_reg == KIND_TOTALS);

endmodule

`default_nettype wire

// ===== hw/rtl/zsbp_checker.sv =====
// Port-level checker for the zero-suppression bitmask packer, with its bind.
`default_nettype none

`include "zero_suppression_bitmask_packer_macros.svh"

module zsbp_checker #(
    parameter int COUNT_WIDTH = 40
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [1:0]                   item_kind,
    input wire logic [zsbp_pkg::VALUE_W-1:0] payload,
    input wire logic [COUNT_WIDTH-1:0]       samples_seen,
    input wire logic [COUNT_WIDTH-1:0]       nonzero_seen,
    input wire logic                         end_of_run
);
    import zsbp_pkg::*;

    `ZSBP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(payload) && $stable(item_kind), "stalled output transfer changed")
    `ZSBP_ASSERT(a_end_kind, out_valid |-> (end_of_run == (item_kind == KIND_TOTALS)), "end_of_run does not match totals kind")
    `ZSBP_ASSERT(a_totals_payload, out_valid && item_kind == KIND_TOTALS |-> payload == '0, "totals transfer carries nonzero payload")
    `ZSBP_ASSERT(a_count_order, out_valid |-> nonzero_seen <= samples_seen, "nonzero count exceeds sample count")
    `ZSBP_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind zero_suppression_bitmask_packer zsbp_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_zsbp_checker (.*);

`default_nettype wire
